// ===== src/dual_source_switch_controller_assert.svh =====
// Assertion macros shared by the controller RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef DUAL_SOURCE_SWITCH_CONTROLLER_ASSERT_SVH
`define DUAL_SOURCE_SWITCH_CONTROLLER_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define DSSC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dssc assertion failed");

// Next-cycle implication, quiet during reset.
`define DSSC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dssc assertion failed");

`endif

// ===== src/dssc_pkg.sv =====
`timescale 1ns / 1ps
package dssc_pkg;

	// Command codes carried in s_axis_tuser
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2
	} cmd_t;

	// Wait phase codes
	typedef enum logic [2:0] {
		PH_NONE        = 3'd0,
		PH_FIRST_WAIT  = 3'd1,
		PH_FIRST_OVER  = 3'd2,
		PH_SECOND_WAIT = 3'd3,
		PH_SECOND_OVER = 3'd4
	} phase_t;

	// Source selection state that the rules act on
	typedef struct packed {
		logic   server_on;
		logic   peer_on;
		phase_t phase;
	} sw_state_t;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_FIRST_WAIT  = 2'd0;
	localparam logic [1:0] REG_SECOND_WAIT = 2'd1;
	localparam logic [1:0] REG_LOW_SPEED   = 2'd2;
	localparam logic [1:0] REG_HIGH_SPEED  = 2'd3;

	// Register reset values
	localparam logic [23:0] FIRST_WAIT_RST  = 24'd10000;
	localparam logic [23:0] SECOND_WAIT_RST = 24'd20000;
	localparam logic [31:0] LOW_SPEED_RST   = 32'd10240;
	localparam logic [31:0] HIGH_SPEED_RST  = 32'd20480;

	// Rule firings allowed per evaluation
	localparam int STEP_LIMIT = 8;
	localparam int CNT_W      = $clog2(STEP_LIMIT);

	// Sequencer program steps
	typedef logic [1:0] step_t;
	localparam step_t STEP_ACCEPT = 2'd0;
	localparam step_t STEP_APPLY  = 2'd1;
	localparam step_t STEP_FIRE   = 2'd2;
	localparam step_t STEP_EMIT   = 2'd3;

	// Datapath operations
	typedef enum logic [1:0] {
		OP_CAPTURE,
		OP_APPLY,
		OP_FIRE,
		OP_EMIT
	} uop_t;

	// Jump conditions: jump to target when true, else fall through
	typedef enum logic [1:0] {
		CND_NO_IN,
		CND_NO_EVAL,
		CND_RULE_MORE,
		CND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t tgt;
	} ucode_t;

	// Control program, one word per step
	localparam ucode_t UCODE_ROM [4] = '{
		'{op: OP_CAPTURE, cond: CND_NO_IN,     tgt: STEP_ACCEPT},
		'{op: OP_APPLY,   cond: CND_NO_EVAL,   tgt: STEP_EMIT},
		'{op: OP_FIRE,    cond: CND_RULE_MORE, tgt: STEP_FIRE},
		'{op: OP_EMIT,    cond: CND_OUT_BUSY,  tgt: STEP_EMIT}
	};

endpackage

// ===== src/dssc_rules.sv =====
`timescale 1ns / 1ps
module dssc_rules #(
	parameter int TIMER_BITS = 24
) (
	input  dssc_pkg::sw_state_t cur,
	input  logic [TIMER_BITS-1:0] wait_timer,
	input  logic [23:0] first_wait_ms,
	input  logic [23:0] second_wait_ms,
	input  logic [31:0] low_speed,
	input  logic [31:0] high_speed,
	input  logic [15:0] connected_peers,
	input  logic [15:0] pooled_peers,
	input  logic [15:0] active_peers,
	input  logic [15:0] available_peers,
	input  logic [31:0] peer_speed,
	output dssc_pkg::sw_state_t nxt,
	output logic clr_timer,
	output logic fired
);
	import dssc_pkg::*;

	localparam int CW = (TIMER_BITS > 24) ? TIMER_BITS : 24;

	logic first_done;
	logic second_done;
	logic speed_ok;
	logic speed_high;

	// Threshold compares shared by the rules
	assign first_done  = CW'(wait_timer) >= CW'(first_wait_ms);
	assign second_done = CW'(wait_timer) >= CW'(second_wait_ms);
	assign speed_ok    = peer_speed >= low_speed;
	assign speed_high  = peer_speed >= high_speed;

	// Fire one rule chosen by server, peer and phase
	always_comb begin
		nxt       = cur;
		clr_timer = 1'b0;
		fired     = 1'b0;
		case ({cur.server_on, cur.peer_on, cur.phase})
			{1'b0, 1'b0, PH_NONE}: begin
				nxt.peer_on = 1'b1;
				nxt.phase   = PH_FIRST_WAIT;
				clr_timer   = 1'b1;
				fired       = 1'b1;
			end
			{1'b0, 1'b1, PH_FIRST_WAIT}: begin
				if (first_done) begin
					nxt.phase = PH_FIRST_OVER;
					fired     = 1'b1;
				end
			end
			{1'b0, 1'b1, PH_FIRST_OVER}: begin
				fired = 1'b1;
				if (connected_peers == 16'd0 || pooled_peers == 16'd0) begin
					nxt.server_on = 1'b1;
					nxt.peer_on   = 1'b0;
					nxt.phase     = PH_NONE;
				end else begin
					clr_timer = 1'b1;
					nxt.phase = PH_SECOND_WAIT;
				end
			end
			{1'b0, 1'b1, PH_SECOND_WAIT}: begin
				if (second_done) begin
					nxt.phase = PH_SECOND_OVER;
					fired     = 1'b1;
				end
			end
			{1'b0, 1'b1, PH_SECOND_OVER}: begin
				fired     = 1'b1;
				nxt.phase = PH_NONE;
				if (active_peers == 16'd0) begin
					nxt.server_on = 1'b1;
					nxt.peer_on   = 1'b0;
				end else if (!speed_ok) begin
					nxt.server_on = 1'b1;
				end
			end
			{1'b1, 1'b1, PH_NONE}: begin
				if (available_peers == 16'd0) begin
					nxt.peer_on = 1'b0;
					fired       = 1'b1;
				end else if (speed_high) begin
					nxt.server_on = 1'b0;
					fired         = 1'b1;
				end
			end
			{1'b0, 1'b1, PH_NONE}: begin
				if (available_peers == 16'd0) begin
					nxt.server_on = 1'b1;
					nxt.peer_on   = 1'b0;
					fired         = 1'b1;
				end else if (!speed_ok) begin
					nxt.server_on = 1'b1;
					fired         = 1'b1;
				end
			end
			{1'b1, 1'b0, PH_NONE}: begin
				if (available_peers != 16'd0) begin
					nxt.peer_on = 1'b1;
					fired       = 1'b1;
				end
			end
			default: begin
				fired = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/dual_source_switch_controller.sv =====
`timescale 1ns / 1ps
// Dual source switch controller.
// Input stream (s_axis): one command per transfer; tuser carries the command
// (tick, start, stop), tdata carries held, elapsed ms, the peer counts and
// the peer speed. Output stream (m_axis): one result per command with the
// server and peer enables, the wait phase and the running flag.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_idx
// (first wait, second wait, low speed, high speed) in the same edge.
// Sequence: the microcode sequencer captures a command at its accept step,
// applies it at its apply step, then, if the rules must run, steps the rule
// evaluator at its fire step, one rule per cycle, while a rule fires and the
// STEP_LIMIT bound is not reached, and loads the result at its emit step.
// One command is in work at a time; a new command is taken while the
// previous result still waits in the output register.
// Reset: all enables, phase, timer and running flag clear, registers take
// their default values, no result is pending. No clearing pass is needed.
// Stall: when m_axis_tready is low a pending result holds; the sequencer
// waits at its emit step until the output register frees up.
module dual_source_switch_controller #(
	parameter int TIMER_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: held[0], delta_ms[16:1], connected_peers[32:17], pooled_peers[48:33],
	//        active_peers[64:49], available_peers[80:65], peer_speed[112:81]
	input  logic [119:0] s_axis_tdata,
	// tuser: cmd[1:0]
	input  logic [1:0]   s_axis_tuser,
	// output stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: server_enable[0], peer_enable[1], wait_phase[4:2], active[5]
	output logic [7:0]   m_axis_tdata,
	// configuration
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [31:0]  cfg_wdata
);
	import dssc_pkg::*;

	// configuration registers
	logic [23:0] first_wait_q;
	logic [23:0] second_wait_q;
	logic [31:0] low_speed_q;
	logic [31:0] high_speed_q;

	// captured command
	logic [1:0]  cmd_q;
	logic        held_q;
	logic [15:0] delta_q;
	logic [15:0] conn_q;
	logic [15:0] pooled_q;
	logic [15:0] act_q;
	logic [15:0] avail_q;
	logic [31:0] speed_q;

	// controller state
	logic                  running_q;
	sw_state_t             sw_q;
	logic [TIMER_BITS-1:0] timer_q;

	// sequencer
	step_t            pc_q;
	step_t            pc_nxt;
	ucode_t           uw;
	logic             cond_hit;
	logic [CNT_W-1:0] cnt_q;

	// output register
	logic       out_valid_q;
	logic [5:0] out_q;
	logic       out_load;

	// rule evaluator outputs
	sw_state_t rule_nxt;
	logic      rule_clr;
	logic      rule_fired;

	logic                eval_needed;
	logic [TIMER_BITS:0] timer_sum;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_wait_q  <= FIRST_WAIT_RST;
			second_wait_q <= SECOND_WAIT_RST;
			low_speed_q   <= LOW_SPEED_RST;
			high_speed_q  <= HIGH_SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FIRST_WAIT:  first_wait_q  <= cfg_wdata[23:0];
				REG_SECOND_WAIT: second_wait_q <= cfg_wdata[23:0];
				REG_LOW_SPEED:   low_speed_q   <= cfg_wdata;
				REG_HIGH_SPEED:  high_speed_q  <= cfg_wdata;
				default:         first_wait_q  <= first_wait_q;
			endcase
		end
	end

	// Fetch the control word and resolve the jump
	always_comb begin
		uw = UCODE_ROM[pc_q];
		case (uw.cond)
			CND_NO_IN:     cond_hit = !s_axis_tvalid;
			CND_NO_EVAL:   cond_hit = !eval_needed;
			CND_RULE_MORE: cond_hit = rule_fired && (cnt_q != CNT_W'(STEP_LIMIT - 1));
			CND_OUT_BUSY:  cond_hit = out_valid_q && !m_axis_tready;
			default:       cond_hit = 1'b0;
		endcase
		pc_nxt = cond_hit ? uw.tgt : step_t'(pc_q + 2'd1);
	end

	assign s_axis_tready = (uw.op == OP_CAPTURE);
	assign out_load      = (uw.op == OP_EMIT) && (!out_valid_q || m_axis_tready);

	// Decide at apply whether the rules run for this command
	always_comb begin
		case (cmd_q)
			CMD_START: eval_needed = !running_q && !held_q;
			CMD_TICK:  eval_needed = running_q && !held_q;
			default:   eval_needed = 1'b0;
		endcase
	end

	assign timer_sum = {1'b0, timer_q} + (TIMER_BITS + 1)'(delta_q);

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_ACCEPT;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	// Capture the command on transfer
	always_ff @(posedge clk) begin
		if (uw.op == OP_CAPTURE && s_axis_tvalid) begin
			cmd_q    <= s_axis_tuser;
			held_q   <= s_axis_tdata[0];
			delta_q  <= s_axis_tdata[16:1];
			conn_q   <= s_axis_tdata[32:17];
			pooled_q <= s_axis_tdata[48:33];
			act_q    <= s_axis_tdata[64:49];
			avail_q  <= s_axis_tdata[80:65];
			speed_q  <= s_axis_tdata[112:81];
		end
	end

	// Apply the command, then fire rules one per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			sw_q      <= '{server_on: 1'b0, peer_on: 1'b0, phase: PH_NONE};
			timer_q   <= '0;
			cnt_q     <= '0;
		end else begin
			case (uw.op)
				OP_APPLY: begin
					cnt_q <= '0;
					case (cmd_q)
						CMD_START: begin
							if (!running_q) begin
								running_q <= 1'b1;
								sw_q      <= '{server_on: 1'b0, peer_on: 1'b0,
									phase: PH_NONE};
								timer_q   <= '0;
							end
						end
						CMD_STOP: running_q <= 1'b0;
						CMD_TICK: begin
							if (running_q) begin
								timer_q <= timer_sum[TIMER_BITS] ? '1 :
									timer_sum[TIMER_BITS-1:0];
							end
						end
						default: running_q <= running_q;
					endcase
				end
				OP_FIRE: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (rule_fired) begin
						sw_q <= rule_nxt;
						if (rule_clr) begin
							timer_q <= '0;
						end
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= {running_q, sw_q.phase, sw_q.peer_on, sw_q.server_on};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q};

	dssc_rules #(
		.TIMER_BITS(TIMER_BITS)
	) u_rules (
		.cur             (sw_q),
		.wait_timer      (timer_q),
		.first_wait_ms   (first_wait_q),
		.second_wait_ms  (second_wait_q),
		.low_speed       (low_speed_q),
		.high_speed      (high_speed_q),
		.connected_peers (conn_q),
		.pooled_peers    (pooled_q),
		.active_peers    (act_q),
		.available_peers (avail_q),
		.peer_speed      (speed_q),
		.nxt             (rule_nxt),
		.clr_timer       (rule_clr),
		.fired           (rule_fired)
	);

`include "dual_source_switch_controller_assert.svh"

	// a captured command is always applied next
	`DSSC_ASSERT_NXT(a_apply_after_in, s_axis_tvalid && s_axis_tready, pc_q == STEP_APPLY)
	// rules run only while the controller is running
	`DSSC_ASSERT_IMP(a_fire_running, pc_q == STEP_FIRE, running_q)
	// the rule chain ends at the step limit
	`DSSC_ASSERT_NXT(a_chain_bound, pc_q == STEP_FIRE && cnt_q == CNT_W'(STEP_LIMIT - 1),
		pc_q == STEP_EMIT)
	// phase never leaves the defined codes
	`DSSC_ASSERT_IMP(a_phase_range, 1'b1, sw_q.phase <= PH_SECOND_OVER)

endmodule

// ===== dv/tb_dual_source_switch_controller.sv =====
`timescale 1ns / 1ps
module tb_dual_source_switch_controller;
	import dssc_pkg::*;

	// Command code with no meaning to the block
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int TMR_W = 24;
	localparam int LATENCY_PAD = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD_AT = 300;
	localparam int LONG_HOLD_CYCLES = 400;

	typedef struct {
		logic [1:0]  cmd;
		logic        held;
		logic [15:0] delta;
		logic [15:0] conn;
		logic [15:0] pooled;
		logic [15:0] act;
		logic [15:0] avail;
		logic [31:0] speed;
	} cmd_item_t;

	typedef struct {
		logic       server_en;
		logic       peer_en;
		logic [2:0] wait_phase;
		logic       active;
	} selection_t;

	// Mirror of the source selector: state, thresholds and pending selections
	class source_select_model;
		logic [23:0] first_wait;
		logic [23:0] second_wait;
		logic [31:0] low_speed;
		logic [31:0] high_speed;
		bit running;
		bit server_on;
		bit peer_on;
		phase_t phase;
		logic [TMR_W-1:0] wait_timer;
		selection_t expected_sel_q[$];
		int n_checked;
		int n_fail;

		function new();
			first_wait = FIRST_WAIT_RST;
			second_wait = SECOND_WAIT_RST;
			low_speed = LOW_SPEED_RST;
			high_speed = HIGH_SPEED_RST;
			running = 1'b0;
			server_on = 1'b0;
			peer_on = 1'b0;
			phase = PH_NONE;
			wait_timer = '0;
			n_checked = 0;
			n_fail = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_FIRST_WAIT: first_wait = val[23:0];
				REG_SECOND_WAIT: second_wait = val[23:0];
				REG_LOW_SPEED: low_speed = val;
				REG_HIGH_SPEED: high_speed = val;
				default: ;
			endcase
		endfunction

		// Apply one transition; report whether anything changed
		function bit fire_rule(cmd_item_t it);
			bit fired;
			fired = 1'b0;
			case ({server_on, peer_on, phase})
				{2'b00, PH_NONE}: begin
					peer_on = 1'b1;
					wait_timer = '0;
					phase = PH_FIRST_WAIT;
					fired = 1'b1;
				end
				{2'b01, PH_FIRST_WAIT}: begin
					if (wait_timer >= first_wait) begin
						phase = PH_FIRST_OVER;
						fired = 1'b1;
					end
				end
				{2'b01, PH_FIRST_OVER}: begin
					fired = 1'b1;
					if (it.conn == 0 || it.pooled == 0) begin
						server_on = 1'b1;
						peer_on = 1'b0;
						phase = PH_NONE;
					end else begin
						wait_timer = '0;
						phase = PH_SECOND_WAIT;
					end
				end
				{2'b01, PH_SECOND_WAIT}: begin
					if (wait_timer >= second_wait) begin
						phase = PH_SECOND_OVER;
						fired = 1'b1;
					end
				end
				{2'b01, PH_SECOND_OVER}: begin
					fired = 1'b1;
					phase = PH_NONE;
					if (it.act == 0) begin
						server_on = 1'b1;
						peer_on = 1'b0;
					end else if (it.speed < low_speed) begin
						server_on = 1'b1;
					end
				end
				{2'b11, PH_NONE}: begin
					if (it.avail == 0) begin
						peer_on = 1'b0;
						fired = 1'b1;
					end else if (it.speed >= high_speed) begin
						server_on = 1'b0;
						fired = 1'b1;
					end
				end
				{2'b01, PH_NONE}: begin
					if (it.avail == 0) begin
						server_on = 1'b1;
						peer_on = 1'b0;
						fired = 1'b1;
					end else if (it.speed < low_speed) begin
						server_on = 1'b1;
						fired = 1'b1;
					end
				end
				{2'b10, PH_NONE}: begin
					if (it.avail != 0) begin
						peer_on = 1'b1;
						fired = 1'b1;
					end
				end
				default: ;
			endcase
			return fired;
		endfunction

		// Chain transitions, bounded per evaluation
		function void evaluate(cmd_item_t it);
			for (int k = 0; k < STEP_LIMIT; k++) begin
				if (!fire_rule(it))
					break;
			end
		endfunction

		// Update state for an accepted command and queue its selection
		function void note_command(cmd_item_t it);
			logic [TMR_W:0] acc;
			selection_t sel;
			case (it.cmd)
				CMD_START: begin
					if (!running) begin
						running = 1'b1;
						server_on = 1'b0;
						peer_on = 1'b0;
						phase = PH_NONE;
						wait_timer = '0;
						if (!it.held)
							evaluate(it);
					end
				end
				CMD_STOP: running = 1'b0;
				CMD_TICK: begin
					if (running) begin
						acc = {1'b0, wait_timer} + (TMR_W + 1)'(it.delta);
						wait_timer = acc[TMR_W] ? '1 : acc[TMR_W-1:0];
						if (!it.held)
							evaluate(it);
					end
				end
				default: ;
			endcase
			sel.server_en = server_on;
			sel.peer_en = peer_on;
			sel.wait_phase = phase;
			sel.active = running;
			expected_sel_q.push_back(sel);
		endfunction

		// Compare one output transfer with the oldest pending selection
		function void check_selection(logic [7:0] d);
			selection_t exp_sel;
			n_checked++;
			if (expected_sel_q.size() == 0) begin
				$error("unexpected result transfer, tdata %0h", d);
				n_fail++;
				return;
			end
			exp_sel = expected_sel_q.pop_front();
			if (d[0] !== exp_sel.server_en) begin
				$error("server_enable: expected %0d, got %0d", exp_sel.server_en, d[0]);
				n_fail++;
			end
			if (d[1] !== exp_sel.peer_en) begin
				$error("peer_enable: expected %0d, got %0d", exp_sel.peer_en, d[1]);
				n_fail++;
			end
			if (d[4:2] !== exp_sel.wait_phase) begin
				$error("wait_phase: expected %0d, got %0d", exp_sel.wait_phase, d[4:2]);
				n_fail++;
			end
			if (d[5] !== exp_sel.active) begin
				$error("active: expected %0d, got %0d", exp_sel.active, d[5]);
				n_fail++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// tdata: held, delta_ms, connected_peers, pooled_peers, active_peers,
	//        available_peers, peer_speed
	logic [119:0] s_axis_tdata = '0;
	// tuser: cmd
	logic [1:0] s_axis_tuser = 2'd0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// tdata: server_enable, peer_enable, wait_phase, active
	logic [7:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = 2'd0;
	logic [31:0] cfg_wdata = '0;

	source_select_model model = new();
	int n_sent = 0;
	int n_settings = 0;

	dual_source_switch_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic cmd_item_t mk(logic [1:0] cmd, logic held, logic [15:0] delta,
			logic [15:0] conn, logic [15:0] pooled, logic [15:0] act,
			logic [15:0] avail, logic [31:0] speed);
		cmd_item_t it;
		it.cmd = cmd;
		it.held = held;
		it.delta = delta;
		it.conn = conn;
		it.pooled = pooled;
		it.act = act;
		it.avail = avail;
		it.speed = speed;
		return it;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Peer counts: zero often, small values, full range and the maximum
	function automatic logic [15:0] pick_count();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return 16'd0;
		else if (r < 6)
			return 16'($urandom_range(1, 3));
		else if (r < 8)
			return 16'($urandom);
		else if (r == 8)
			return 16'hFFFF;
		return 16'($urandom_range(4, 40));
	endfunction

	// Speeds clustered on both thresholds
	function automatic logic [31:0] pick_speed();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return model.low_speed - 1;
			2: return model.low_speed;
			3: return model.low_speed + 1;
			4: return model.high_speed - 1;
			5: return model.high_speed;
			6: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_delta(bit big);
		int r;
		r = $urandom_range(0, 99);
		if (big)
			return (r < 90) ? 16'hFFFF : 16'($urandom);
		if (r < 10)
			return 16'd0;
		else if (r < 30)
			return 16'($urandom_range(1, 100));
		else if (r < 40)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// Offer one command and hold it until the block takes the transfer
	task automatic send_cmd(input cmd_item_t it, input bit calm);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, it.speed, it.avail, it.act, it.pooled, it.conn,
			it.delta, it.held};
		s_axis_tuser <= it.cmd;
		do @(posedge clk); while (!s_axis_tready);
		model.note_command(it);
		n_sent++;
	endtask

	// Stop offering and wait out every pending selection
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (model.expected_sel_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		model.set_reg(idx, val);
	endtask

	task automatic write_regs(input logic [23:0] fw, input logic [23:0] sw,
			input logic [31:0] lo, input logic [31:0] hi);
		put_reg(REG_FIRST_WAIT, {8'd0, fw});
		put_reg(REG_SECOND_WAIT, {8'd0, sw});
		put_reg(REG_LOW_SPEED, lo);
		put_reg(REG_HIGH_SPEED, hi);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Random sessions: start when stopped, then mostly ticks with random peers
	task automatic run_random(input int n, input bit big_delta, input bit no_stop);
		cmd_item_t it;
		int r;
		bit calm;
		for (int i = 0; i < n; i++) begin
			calm = ((i / 40) % 3) == 2;
			r = $urandom_range(0, 99);
			if (!model.running) begin
				if (r < 85)
					it.cmd = CMD_START;
				else if (r < 90)
					it.cmd = CMD_TICK;
				else if (r < 95)
					it.cmd = CMD_STOP;
				else
					it.cmd = CMD_NOP;
			end else if (no_stop) begin
				if (r < 97)
					it.cmd = CMD_TICK;
				else if (r < 99)
					it.cmd = CMD_START;
				else
					it.cmd = CMD_NOP;
			end else begin
				if (r < 88)
					it.cmd = CMD_TICK;
				else if (r < 92)
					it.cmd = CMD_STOP;
				else if (r < 96)
					it.cmd = CMD_START;
				else
					it.cmd = CMD_NOP;
			end
			it.held = ($urandom_range(0, 9) == 0);
			it.delta = pick_delta(big_delta);
			it.conn = pick_count();
			it.pooled = pick_count();
			it.act = pick_count();
			it.avail = pick_count();
			it.speed = pick_speed();
			send_cmd(it, calm);
		end
		drain();
	endtask

	// Result side: random stalls, calm stretches, one long hold-off
	initial begin : result_sink
		int stall_left;
		int seen;
		int cyc;
		bit long_done;
		bit calm;
		stall_left = 0;
		seen = 0;
		cyc = 0;
		long_done = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			calm = ((cyc / 128) % 4) == 3;
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				model.check_selection(m_axis_tdata);
				seen++;
			end
			if (!long_done && seen >= LONG_HOLD_AT) begin
				stall_left = LONG_HOLD_CYCLES;
				long_done = 1'b1;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!calm)
					stall_left = pick_gap();
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		int unsigned cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb_dual_source_switch_controller: errors");
		$finish;
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through most rule branches at reset thresholds
		send_cmd(mk(CMD_TICK, 0, 100, 1, 1, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_STOP, 0, 0, 0, 0, 0, 0, 0), 1'b0);
		send_cmd(mk(CMD_NOP, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF), 1'b0);
		send_cmd(mk(CMD_START, 1, 500, 1, 1, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 1, 16'hFFFF, 1, 1, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 0, 1, 1, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_START, 0, 0, 0, 0, 0, 0, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 9999, 1, 1, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 1, 0, 5, 1, 0, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 7, 1, 1, 1, 1, 32'hFFFF_FFFF), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 7, 1, 1, 1, 2, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 7, 1, 1, 1, 0, 0), 1'b0);
		send_cmd(mk(CMD_STOP, 0, 0, 0, 0, 0, 0, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 16'hFFFF, 1, 1, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_START, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 16'hFFFF, 1, 1, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 19999, 1, 1, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 1, 1, 1, 3, 1, 10240), 1'b0);
		send_cmd(mk(CMD_STOP, 0, 0, 0, 0, 0, 0, 0), 1'b0);
		send_cmd(mk(CMD_START, 0, 0, 1, 1, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 16'hFFFF, 1, 1, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 16'hFFFF, 1, 1, 0, 1, 20480), 1'b0);
		send_cmd(mk(CMD_STOP, 0, 0, 0, 0, 0, 0, 0), 1'b0);
		send_cmd(mk(CMD_START, 0, 0, 1, 1, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 16'hFFFF, 1, 1, 1, 1, 0), 1'b0);
		send_cmd(mk(CMD_TICK, 0, 16'hFFFF, 1, 1, 2, 0, 10239), 1'b0);
		send_cmd(mk(CMD_TICK, 1, 16'hFFFF, 0, 0, 0, 0, 0), 1'b0);
		drain();

		// Zero waits and thresholds: every rule fires at once
		write_regs(24'd0, 24'd0, 32'd0, 32'd0);
		run_random(150, 1'b0, 1'b0);

		// Maximum waits: the first wait ends only at timer saturation
		write_regs(24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random(350, 1'b1, 1'b1);

		// Fast threshold below the slow one: enables toggle until the chain bound
		write_regs(24'd5000, 24'd3000, 32'd20480, 32'd100);
		run_random(150, 1'b0, 1'b0);

		// Random thresholds
		write_regs(24'($urandom_range(0, 150000)), 24'($urandom_range(0, 150000)),
			$urandom, $urandom);
		run_random(150, 1'b0, 1'b0);

		// Back to the power-up values
		write_regs(FIRST_WAIT_RST, SECOND_WAIT_RST, LOW_SPEED_RST, HIGH_SPEED_RST);
		run_random(125, 1'b0, 1'b0);

		if (model.expected_sel_q.size() != 0) begin
			$error("%0d expected results never arrived", model.expected_sel_q.size());
			model.n_fail++;
		end
		$display("Run: %0d commands, %0d results checked, %0d threshold settings.",
			n_sent, model.n_checked, n_settings);
		$display("Covered held ticks, restarts, stops, timer saturation and inverted speeds.");
		if (model.n_fail == 0)
			$display("tb_dual_source_switch_controller: clean");
		else
			$display("tb_dual_source_switch_controller: errors");
		$finish;
	end

endmodule
